// ----- hdl/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

   // queue geometry
   localparam int DEPTH         = 16;
   localparam int PRIORITY_BITS = 8;
   localparam int IDX_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W         = $clog2(DEPTH + 1);

   // field widths of the transaction payloads
   localparam int DATA_W   = 8;
   localparam int FPRIO_W  = 8;
   localparam int STATUS_W = 2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // operation codes
   localparam logic MODE_ENQ = 1'b0;
   localparam logic MODE_DEQ = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [DATA_W-1:0]  item_data;
      logic [FPRIO_W-1:0] item_priority;
   } spq_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   out_data;
      logic [FPRIO_W-1:0]  out_priority;
      logic [CNT_W-1:0]    fill_level;
   } spq_rsp_type;

   // one stored entry
   typedef struct packed {
      logic [PRIORITY_BITS-1:0] prio;
      logic [DATA_W-1:0]        data;
   } spq_entry_type;

   // field priority to stored priority: high bits dropped, or zero extended
   function automatic logic [PRIORITY_BITS-1:0] to_prio(input logic [FPRIO_W-1:0] p);
      logic [PRIORITY_BITS-1:0] r;
      r = '0;
      for (int i = 0; i < PRIORITY_BITS; i++) begin
         if (i < FPRIO_W) begin
            r[i] = p[i];
         end
      end
      return r;
   endfunction

   // stored priority back to field width
   function automatic logic [FPRIO_W-1:0] from_prio(input logic [PRIORITY_BITS-1:0] p);
      logic [FPRIO_W-1:0] r;
      r = '0;
      for (int i = 0; i < FPRIO_W; i++) begin
         if (i < PRIORITY_BITS) begin
            r[i] = p[i];
         end
      end
      return r;
   endfunction

endpackage

// ----- hdl/spq_ram.sv -----
`timescale 1ns / 1ps

module spq_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/stable_priority_queue.sv -----
`timescale 1ns / 1ps

// Sorted priority queue of DEPTH byte entries: higher priority leaves first,
// equal priorities leave in arrival order. A transaction is taken when start
// is high and busy is low; its single result appears one cycle on rsp_item
// with rsp_valid and cannot be held off. Entries sit in one single-port-write,
// registered-read memory that a small sequencer walks one slot per cycle, so
// busy stays high while an enqueue moves back each lower-priority entry and
// then makes the final compare or, if every entry moved, the front write, and
// while a dequeue reads the front and moves each later entry forward. Full
// enqueue, empty dequeue and enqueue into an empty queue leave busy low. The
// result strobe comes in the cycle after the last busy cycle (or acceptance).
module stable_priority_queue
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  spq_req_type req_item,
   output logic        rsp_valid,
   output spq_rsp_type rsp_item
);

   typedef enum logic [4:0] {
      S_IDLE      = 5'b00001,
      S_INS_CMP   = 5'b00010,
      S_INS_PLACE = 5'b00100,
      S_POP_HEAD  = 5'b01000,
      S_POP_SHIFT = 5'b10000
   } state_type;

   state_type     state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] k_ff, k_in;
   spq_entry_type new_ff, new_in;
   spq_entry_type pop_ff, pop_in;
   logic          rsp_valid_ff, rsp_valid_in;
   spq_rsp_type   rsp_ff, rsp_in;

   logic          wr_en;
   logic [IDX_W-1:0] wr_addr;
   spq_entry_type wr_data;
   logic [IDX_W-1:0] rd_addr;
   spq_entry_type rd_q;
   logic [CNT_W-1:0] k_dn, k_dn2, k_up, cnt_dn, cnt_up;
   logic          accept;

   spq_ram #(
      .WIDTH  ($bits(spq_entry_type)),
      .DEPTH  (DEPTH),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_q)
   );

   assign accept = start && (state_ff == S_IDLE);
   assign k_dn   = k_ff - CNT_W'(1);
   assign k_dn2  = k_ff - CNT_W'(2);
   assign k_up   = k_ff + CNT_W'(1);
   assign cnt_dn = count_ff - CNT_W'(1);
   assign cnt_up = count_ff + CNT_W'(1);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      new_in       = new_ff;
      pop_in       = pop_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = k_ff[IDX_W-1:0];
      wr_data      = new_ff;
      rd_addr      = '0;

      unique case (state_ff)
         S_IDLE: begin
            new_in.data = req_item.item_data;
            new_in.prio = to_prio(req_item.item_priority);
            if (accept) begin
               rsp_in.out_data     = '0;
               rsp_in.out_priority = '0;
               if (req_item.mode == MODE_ENQ) begin
                  if (count_ff >= CNT_W'(DEPTH)) begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.status     = ST_FULL;
                     rsp_in.fill_level = count_ff;
                  end else if (count_ff == '0) begin
                     // empty queue: write straight to the front
                     wr_en             = 1'b1;
                     wr_addr           = '0;
                     wr_data           = new_in;
                     count_in          = cnt_up;
                     rsp_valid_in      = 1'b1;
                     rsp_in.status     = ST_DONE;
                     rsp_in.fill_level = cnt_up;
                  end else begin
                     rd_addr  = cnt_dn[IDX_W-1:0];
                     k_in     = count_ff;
                     state_in = S_INS_CMP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.status     = ST_EMPTY;
                     rsp_in.fill_level = count_ff;
                  end else begin
                     rd_addr  = '0;
                     state_in = S_POP_HEAD;
                  end
               end
            end
         end

         // rd_q holds slot k-1: stop behind it or move it back one slot
         S_INS_CMP: begin
            wr_en = 1'b1;
            if (rd_q.prio >= new_ff.prio) begin
               wr_data           = new_ff;
               count_in          = cnt_up;
               rsp_valid_in      = 1'b1;
               rsp_in.status     = ST_DONE;
               rsp_in.fill_level = cnt_up;
               state_in          = S_IDLE;
            end else begin
               wr_data = rd_q;
               k_in    = k_dn;
               if (k_ff == CNT_W'(1)) begin
                  state_in = S_INS_PLACE;
               end else begin
                  rd_addr = k_dn2[IDX_W-1:0];
               end
            end
         end

         // new entry goes to the front
         S_INS_PLACE: begin
            wr_en             = 1'b1;
            wr_data           = new_ff;
            count_in          = cnt_up;
            rsp_valid_in      = 1'b1;
            rsp_in.status     = ST_DONE;
            rsp_in.fill_level = cnt_up;
            state_in          = S_IDLE;
         end

         // rd_q holds the front entry
         S_POP_HEAD: begin
            pop_in              = rd_q;
            rsp_in.out_data     = rd_q.data;
            rsp_in.out_priority = from_prio(rd_q.prio);
            if (count_ff == CNT_W'(1)) begin
               count_in          = cnt_dn;
               rsp_valid_in      = 1'b1;
               rsp_in.status     = ST_DONE;
               rsp_in.fill_level = cnt_dn;
               state_in          = S_IDLE;
            end else begin
               rd_addr  = IDX_W'(1);
               k_in     = CNT_W'(1);
               state_in = S_POP_SHIFT;
            end
         end

         // rd_q holds slot k: move it forward one slot
         S_POP_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = k_dn[IDX_W-1:0];
            wr_data = rd_q;
            k_in    = k_up;
            if (k_up == count_ff) begin
               count_in            = cnt_dn;
               rsp_valid_in        = 1'b1;
               rsp_in.status       = ST_DONE;
               rsp_in.out_data     = pop_ff.data;
               rsp_in.out_priority = from_prio(pop_ff.prio);
               rsp_in.fill_level   = cnt_dn;
               state_in            = S_IDLE;
            end else begin
               rd_addr = k_up[IDX_W-1:0];
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      new_ff <= new_in;
      pop_ff <= pop_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ----- bench/stable_priority_queue_tb.sv -----
`timescale 1ns / 1ps

module stable_priority_queue_tb;
   import spq_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_OPS     = 2000;
   localparam int PLAN_ROWS      = 17;

   // one row of the directed plan, repeated reps times with data stepping up
   typedef struct packed {
      spq_req_type req;
      logic [5:0]  reps;
      logic        typed;
      spq_rsp_type rsp;
   } plan_row_type;

   localparam plan_row_type PLAN [0:PLAN_ROWS-1] = '{
      // dequeue right after reset
      '{'{MODE_DEQ, 8'h00, 8'h00}, 6'd1, 1'b1, '{ST_EMPTY, 8'h00, 8'h00, CNT_W'(0)}},
      // lowest then highest priority, extreme data
      '{'{MODE_ENQ, 8'hff, 8'h00}, 6'd1, 1'b1, '{ST_DONE, 8'h00, 8'h00, CNT_W'(1)}},
      '{'{MODE_ENQ, 8'h00, 8'hff}, 6'd1, 1'b1, '{ST_DONE, 8'h00, 8'h00, CNT_W'(2)}},
      '{'{MODE_DEQ, 8'h00, 8'h00}, 6'd1, 1'b0, '0},
      '{'{MODE_DEQ, 8'h00, 8'h00}, 6'd1, 1'b1, '{ST_DONE, 8'hff, 8'h00, CNT_W'(0)}},
      '{'{MODE_DEQ, 8'h00, 8'h00}, 6'd1, 1'b1, '{ST_EMPTY, 8'h00, 8'h00, CNT_W'(0)}},
      // ties mixed with neighbors above and below, fill up to the top
      '{'{MODE_ENQ, 8'h10, 8'h80}, 6'd4, 1'b0, '0},
      '{'{MODE_ENQ, 8'h20, 8'h81}, 6'd2, 1'b0, '0},
      '{'{MODE_ENQ, 8'h30, 8'h7f}, 6'd2, 1'b0, '0},
      '{'{MODE_ENQ, 8'h40, 8'hff}, 6'd1, 1'b0, '0},
      '{'{MODE_ENQ, 8'h50, 8'h00}, 6'd7, 1'b0, '0},
      // refused while full
      '{'{MODE_ENQ, 8'haa, 8'hff}, 6'd1, 1'b1, '{ST_FULL, 8'h00, 8'h00, CNT_W'(16)}},
      '{'{MODE_ENQ, 8'h55, 8'h00}, 6'd1, 1'b1, '{ST_FULL, 8'h00, 8'h00, CNT_W'(16)}},
      // drain everything, then once more
      '{'{MODE_DEQ, 8'h00, 8'h00}, 6'd16, 1'b0, '0},
      '{'{MODE_DEQ, 8'hff, 8'hff}, 6'd1, 1'b1, '{ST_EMPTY, 8'h00, 8'h00, CNT_W'(0)}},
      '{'{MODE_ENQ, 8'ha5, 8'h5a}, 6'd1, 1'b1, '{ST_DONE, 8'h00, 8'h00, CNT_W'(1)}},
      '{'{MODE_DEQ, 8'h00, 8'h00}, 6'd1, 1'b1, '{ST_DONE, 8'ha5, 8'h5a, CNT_W'(0)}}
   };

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   spq_req_type req_item;
   logic        rsp_valid;
   spq_rsp_type rsp_item;

   // shadow copy of the sorted store
   logic [DATA_W-1:0]        shadow_data [DEPTH];
   logic [PRIORITY_BITS-1:0] shadow_prio [DEPTH];
   int unsigned              shadow_count;

   spq_rsp_type replies_due [$];
   spq_rsp_type oldest_reply;
   int unsigned mismatch_count;
   int unsigned quiet_cycles;
   bit          no_idle;

   stable_priority_queue dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // reply of one queue operation, updating the shadow store
   function automatic spq_rsp_type queue_op_reply(input spq_req_type r);
      spq_rsp_type              rep;
      logic [PRIORITY_BITS-1:0] p;
      int unsigned              pos;
      rep = '0;
      p = PRIORITY_BITS'(r.item_priority);
      if (r.mode == MODE_ENQ) begin
         if (shadow_count >= DEPTH) begin
            rep.status = ST_FULL;
         end else begin
            // land behind every entry of equal or higher priority
            pos = 0;
            while (pos < shadow_count && shadow_prio[pos] >= p) pos++;
            for (int k = shadow_count; k > pos; k--) begin
               shadow_data[k] = shadow_data[k-1];
               shadow_prio[k] = shadow_prio[k-1];
            end
            shadow_data[pos] = r.item_data;
            shadow_prio[pos] = p;
            shadow_count++;
            rep.status = ST_DONE;
         end
      end else begin
         if (shadow_count == 0) begin
            rep.status = ST_EMPTY;
         end else begin
            rep.status       = ST_DONE;
            rep.out_data     = shadow_data[0];
            rep.out_priority = FPRIO_W'(shadow_prio[0]);
            for (int k = 1; k < shadow_count; k++) begin
               shadow_data[k-1] = shadow_data[k];
               shadow_prio[k-1] = shadow_prio[k];
            end
            shadow_count--;
         end
      end
      rep.fill_level = CNT_W'(shadow_count);
      return rep;
   endfunction

   // offer one transaction, wait for it to be taken, record its reply
   task automatic send_op(input spq_req_type r, input logic typed, input spq_rsp_type fixed);
      spq_rsp_type rep;
      if (!no_idle && $urandom_range(0, 99) < 31) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      rep = queue_op_reply(r);
      replies_due.push_back(typed ? fixed : rep);
   endtask

   // compare each reply with the oldest one awaited
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (replies_due.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %p", $time, rsp_item);
            mismatch_count++;
         end else begin
            oldest_reply = replies_due.pop_front();
            if (rsp_item.status !== oldest_reply.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, oldest_reply.status, rsp_item.status);
               mismatch_count++;
            end
            if (rsp_item.out_data !== oldest_reply.out_data) begin
               $display("%0t: out_data expected %0h actual %0h",
                        $time, oldest_reply.out_data, rsp_item.out_data);
               mismatch_count++;
            end
            if (rsp_item.out_priority !== oldest_reply.out_priority) begin
               $display("%0t: out_priority expected %0h actual %0h",
                        $time, oldest_reply.out_priority, rsp_item.out_priority);
               mismatch_count++;
            end
            if (rsp_item.fill_level !== oldest_reply.fill_level) begin
               $display("%0t: fill_level expected %0d actual %0d",
                        $time, oldest_reply.fill_level, rsp_item.fill_level);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction in either direction
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("stable_priority_queue test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      spq_req_type r;
      int unsigned enq_pct;
      mismatch_count = 0;
      quiet_cycles   = 0;
      shadow_count   = 0;
      no_idle        = 1'b0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_item <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed plan
      foreach (PLAN[i]) begin
         for (int n = 0; n < PLAN[i].reps; n++) begin
            r = PLAN[i].req;
            r.item_data = r.item_data + DATA_W'(n);
            send_op(r, PLAN[i].typed, PLAN[i].rsp);
         end
      end

      // random operations, with the enqueue share swinging to reach full and empty
      enq_pct = 50;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: enq_pct = 85;
               1: enq_pct = 50;
               default: enq_pct = 15;
            endcase
         end
         no_idle = (n >= 600 && n < 1000);
         r.mode      = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
         r.item_data = DATA_W'($urandom_range(0, 255));
         // narrow pools make ties common
         case ($urandom_range(0, 3))
            0: r.item_priority = FPRIO_W'($urandom_range(0, 255));
            1: r.item_priority = FPRIO_W'($urandom_range(0, 3));
            2: r.item_priority = FPRIO_W'($urandom_range(252, 255));
            default: r.item_priority = $urandom_range(0, 1) ? 8'h80 : 8'h7f;
         endcase
         send_op(r, 1'b0, '0);
      end
      start <= 1'b0;

      // let outstanding replies arrive, then watch for strays
      while (replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("stable_priority_queue test passed");
      end else begin
         $display("stable_priority_queue test failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/spq_pkg.sv
hdl/spq_ram.sv
hdl/stable_priority_queue.sv
bench/stable_priority_queue_tb.sv
